FILE: sv/afvs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fade, volume and silence-end unit.
// No dependencies; every other file imports this package.
package afvs_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 32;
   localparam int COUNT_W     = 33;
   localparam int FADE_W      = 24;
   localparam int VOL_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_SONG_FRAMES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_FRAMES    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_VOLUME_PERCENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PLAY_FOREVER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE_FRAMES = 3'd5;

   localparam logic [VOL_W-1:0] VOLUME_RESET = 8'd100;

   // Gain is unsigned Q1.16, never above 1.0
   localparam int GAIN_W = 17;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;
   // 3.0 in Q2.16 for the smoothstep term 3 - 2s
   localparam logic [17:0] SMOOTH_BASE = 18'd196608;
   // Quotient bits of rem * 2^16 / fade, rem never above fade
   localparam int DIV_STEPS = 17;
   localparam int DIV_CNT_W = 5;

   // floor(a / 100) == (a * RECIP_100) >> RECIP_SHIFT for any a below 2^32
   localparam logic [30:0] RECIP_100   = 31'h51EB851F;
   localparam int          RECIP_SHIFT = 37;

   localparam logic signed [SAMPLE_W-1:0] QUIET_LEVEL = 16'sd8;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       stream_done;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic go;
   } lane_ctl_type;

   typedef struct packed {
      logic done;
      logic quiet;
   } lane_stat_type;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_GAIN,
      TS_START,
      TS_SCALE,
      TS_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      GS_IDLE,
      GS_DIV,
      GS_SQUARE,
      GS_CUBE
   } gain_state_type;

endpackage

FILE: sv/audio_fade_volume_silence_end_unit.sv
`timescale 1ns / 1ps
// Stereo output stage: volume in percent, smoothstep fade-out after the song
// length, end of stream after song plus fade frames or a long quiet run.
// One frame is worked on at a time. At full level a frame goes through
// the two lanes; inside the fade the 17-step serial divider of the gain
// unit and its two multiplies come first, and once the stream has ended
// the frame goes straight to the output. The next frame is taken the cycle
// after the result goes to the output register, which holds it while stalled.
// Depends on afvs_pkg, afvs_gain and afvs_lane.
module audio_fade_volume_silence_end_unit
   import afvs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic [FRAME_W-1:0] song_frames_ff;
   logic [FADE_W-1:0]  fade_frames_ff;
   logic [VOL_W-1:0]   volume_percent_ff;
   logic               play_forever_ff;
   logic               silence_enable_ff;
   logic [FRAME_W-1:0] silence_frames_ff;

   top_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] frames_ff, frames_in;
   logic [FRAME_W-1:0] quiet_ff, quiet_in;
   logic               ended_ff, ended_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic [COUNT_W-1:0] total;
   logic [COUNT_W-1:0] rem_full;
   logic               ended_now;
   logic               fade_now;
   logic               gain_start;
   logic               gain_done;
   logic [GAIN_W-1:0]  gain_val;
   lane_ctl_type       lane_ctl;
   lane_stat_type      left_stat, right_stat;
   logic signed [SAMPLE_W-1:0] left_val, right_val;
   logic               quiet_frame;

   assign total     = {1'b0, song_frames_ff} + COUNT_W'(fade_frames_ff);
   assign rem_full  = total - frames_ff;
   assign ended_now = (!play_forever_ff && (frames_ff >= total)) ||
                      (silence_enable_ff && (quiet_ff >= silence_frames_ff));
   assign fade_now  = !play_forever_ff && (frames_ff >= {1'b0, song_frames_ff});
   assign quiet_frame = left_stat.quiet && right_stat.quiet;
   assign csr_ready = 1'b1;

   afvs_gain u_gain (
      .clock (clock),
      .reset (reset),
      .start (gain_start),
      .rem   (rem_full[FADE_W-1:0]),
      .fade  (fade_frames_ff),
      .done  (gain_done),
      .gain  (gain_val)
   );

   afvs_lane u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .sample_in  (req_payload.left_in),
      .volume     (volume_percent_ff),
      .gain       (gain_ff),
      .stat       (left_stat),
      .sample_out (left_val)
   );

   afvs_lane u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .sample_in  (req_payload.right_in),
      .volume     (volume_percent_ff),
      .gain       (gain_ff),
      .stat       (right_stat),
      .sample_out (right_val)
   );

   always_comb begin
      state_in      = state_ff;
      req_stall     = (state_ff != TS_IDLE);
      accept        = req_valid && !req_stall;
      gain_start    = 1'b0;
      lane_ctl.load = accept;
      lane_ctl.go   = 1'b0;
      gain_in       = gain_ff;
      ended_in      = ended_ff;
      frames_in     = frames_ff;
      quiet_in      = quiet_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               ended_in = ended_now;
               if (ended_now) begin
                  state_in = TS_OUT;
               end else if (fade_now) begin
                  gain_start = 1'b1;
                  state_in   = TS_GAIN;
               end else begin
                  gain_in  = GAIN_UNITY;
                  state_in = TS_START;
               end
            end
         end
         TS_GAIN: begin
            if (gain_done) begin
               gain_in  = gain_val;
               state_in = TS_START;
            end
         end
         TS_START: begin
            lane_ctl.go = 1'b1;
            state_in    = TS_SCALE;
         end
         TS_SCALE: begin
            if (left_stat.done && right_stat.done) begin
               state_in = TS_OUT;
            end
         end
         TS_OUT: begin
            // merge the lanes once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (ended_ff) begin
                  rsp_in.left_out    = '0;
                  rsp_in.right_out   = '0;
                  rsp_in.stream_done = 1'b1;
               end else begin
                  rsp_in.left_out    = left_val;
                  rsp_in.right_out   = right_val;
                  rsp_in.stream_done = 1'b0;
                  if (!play_forever_ff) begin
                     frames_in = frames_ff + 1'b1;
                  end
                  if (silence_enable_ff) begin
                     quiet_in = quiet_frame ? quiet_ff + 1'b1 : '0;
                  end
               end
               state_in = TS_IDLE;
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_IDLE;
         frames_ff    <= '0;
         quiet_ff     <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         quiet_ff     <= quiet_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gain_ff <= gain_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         song_frames_ff    <= '0;
         fade_frames_ff    <= '0;
         volume_percent_ff <= VOLUME_RESET;
         play_forever_ff   <= 1'b0;
         silence_enable_ff <= 1'b0;
         silence_frames_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SONG_FRAMES:    song_frames_ff    <= csr_wdata;
            REG_FADE_FRAMES:    fade_frames_ff    <= csr_wdata[FADE_W-1:0];
            REG_VOLUME_PERCENT: volume_percent_ff <= csr_wdata[VOL_W-1:0];
            REG_PLAY_FOREVER:   play_forever_ff   <= csr_wdata[0];
            REG_SILENCE_ENABLE: silence_enable_ff <= csr_wdata[0];
            REG_SILENCE_FRAMES: silence_frames_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sv/afvs_gain.sv
`timescale 1ns / 1ps
// Smoothstep fade gain: serial restoring divider for s = rem/fade in Q1.16,
// then s*s and s2*(3-2s), one multiply per cycle. Depends on afvs_pkg.
module afvs_gain
   import afvs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FADE_W-1:0] rem,
   input  logic [FADE_W-1:0] fade,
   output logic              done,
   output logic [GAIN_W-1:0] gain
);

   gain_state_type         state_ff, state_in;
   logic [FADE_W-1:0]      part_ff, part_in;
   logic [DIV_STEPS-1:0]   bits_ff, bits_in;
   logic [DIV_STEPS-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [GAIN_W-1:0]      s2_ff, s2_in;
   logic [17:0]            t_ff, t_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic                   done_ff, done_in;

   logic [FADE_W:0]        trial;
   logic [FADE_W:0]        diff;
   logic                   fits;
   logic [33:0]            sq_prod;
   logic [34:0]            cube_prod;

   assign trial     = {part_ff, bits_ff[DIV_STEPS-1]};
   assign diff      = trial - {1'b0, fade};
   assign fits      = (trial >= {1'b0, fade});
   assign sq_prod   = 34'(quo_ff) * 34'(quo_ff);
   assign cube_prod = 35'(s2_ff) * 35'(t_ff);

   always_comb begin
      state_in = state_ff;
      part_in  = part_ff;
      bits_in  = bits_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      s2_in    = s2_ff;
      t_in     = t_ff;
      gain_in  = gain_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         GS_IDLE: begin
            if (start) begin
               // quotient bits above Q1.16 are zero since rem <= fade
               part_in  = {1'b0, rem[FADE_W-1:1]};
               bits_in  = {rem[0], {(DIV_STEPS-1){1'b0}}};
               quo_in   = '0;
               cnt_in   = DIV_CNT_W'(DIV_STEPS - 1);
               state_in = GS_DIV;
            end
         end
         GS_DIV: begin
            part_in = fits ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
            quo_in  = {quo_ff[DIV_STEPS-2:0], fits};
            bits_in = {bits_ff[DIV_STEPS-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = GS_SQUARE;
            end
         end
         GS_SQUARE: begin
            s2_in    = sq_prod[32:16];
            t_in     = SMOOTH_BASE - {quo_ff, 1'b0};
            state_in = GS_CUBE;
         end
         GS_CUBE: begin
            gain_in  = cube_prod[32:16];
            done_in  = 1'b1;
            state_in = GS_IDLE;
         end
         default: begin
            state_in = GS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      part_ff <= part_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      s2_ff   <= s2_in;
      t_ff    <= t_in;
      gain_ff <= gain_in;
   end

   assign done = done_ff;
   assign gain = gain_ff;

endmodule

FILE: sv/afvs_lane.sv
`timescale 1ns / 1ps
// One channel lane: sample times volume times gain, divide by 100 * 2^16
// toward zero, saturate to int16; also flags a quiet sample. Uses afvs_pkg.
module afvs_lane
   import afvs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctl_type               ctl,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic [VOL_W-1:0]           volume,
   input  logic [GAIN_W-1:0]          gain,
   output lane_stat_type              stat,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   localparam int STAGES = 5;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [STAGES-1:0]          vld_ff, vld_in;

   logic signed [VOL_W:0]      vol_s;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [24:0]         prod1_ff, prod1_in;
   logic signed [42:0]         prod2_ff, prod2_in;
   logic signed [42:0]         mag_full;
   logic                       neg_ff;
   logic [23:0]                mag_ff;
   logic [54:0]                recip_ff, recip_in;
   logic [17:0]                quo;
   logic signed [SAMPLE_W-1:0] sat_in;
   logic signed [SAMPLE_W-1:0] out_ff;

   assign vol_s    = signed'({1'b0, volume});
   assign gain_s   = signed'({1'b0, gain});
   assign prod1_in = sample_ff * vol_s;
   assign prod2_in = prod1_ff * gain_s;
   assign mag_full = prod2_ff[42] ? -prod2_ff : prod2_ff;
   assign recip_in = 55'(mag_ff) * 55'(RECIP_100);
   assign quo      = recip_ff[54:RECIP_SHIFT];
   assign vld_in   = {vld_ff[STAGES-2:0], ctl.go};

   always_comb begin
      if (neg_ff) begin
         sat_in = (quo > 18'd32768) ? 16'sh8000 : SAMPLE_W'(-quo);
      end else begin
         sat_in = (quo > 18'd32767) ? 16'sh7FFF : SAMPLE_W'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (ctl.load) begin
         sample_ff <= sample_in;
      end
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      // magnitude stays below 2^39, so bits 39..16 carry the whole shifted value
      neg_ff   <= prod2_ff[42];
      mag_ff   <= mag_full[39:16];
      recip_ff <= recip_in;
      if (vld_ff[STAGES-2]) begin
         out_ff <= sat_in;
      end
   end

   assign stat.done  = vld_ff[STAGES-1];
   assign stat.quiet = (sample_ff <= QUIET_LEVEL) && (sample_ff >= -QUIET_LEVEL);
   assign sample_out = out_ff;

endmodule
